@@ src/ras_pkg.sv @@
// shared types and constants for the room allocation scheduler
// no dependencies; imported by room_allocation_scheduler_unit
`default_nettype none

package ras_pkg;

    localparam int START_W   = 32;
    localparam int TSTAMP_W  = 48;
    localparam int ROOM_W    = 4;
    localparam int CFG_W     = 5;
    localparam int CFG_RESET = 16;

    typedef logic [START_W-1:0]  start_t;
    typedef logic [TSTAMP_W-1:0] tstamp_t;
    typedef logic [ROOM_W-1:0]   room_t;
    typedef logic [CFG_W-1:0]    cfg_t;

    localparam tstamp_t TSTAMP_MAX = '1;

endpackage

`default_nettype wire

@@ src/room_allocation_scheduler_unit.sv @@
// room allocation scheduler: per-room busy-until and use-count memories
// depends on ras_pkg
// a result is registered as the done state ends, after a scan over the n rooms in use; out_stall can hold done
// in_stall holds new beats outside idle, so the single read port scan over the rooms bounds the job rate
// the scan reads one room per cycle from the busy and count memories, with registered read data
// reset: room count 16, all rooms free with zero use, no result pending
// room state is cleared at once on the last job of a set, through per-room valid bits
`default_nettype none

module room_allocation_scheduler_unit #(
    parameter int MAX_ROOMS  = 16,
    parameter int COUNT_BITS = 20
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   room_count_wr_en,
    input  wire  ras_pkg::cfg_t   room_count_wr_data,
    input  wire                   in_valid,
    output logic                  in_stall,
    input  wire  ras_pkg::start_t job_start,
    input  wire  ras_pkg::start_t job_end,
    input  wire                   is_last,
    output logic                  out_valid,
    input  wire                   out_stall,
    output ras_pkg::room_t        room,
    output ras_pkg::tstamp_t      actual_end,
    output logic                  busiest_valid,
    output ras_pkg::room_t        busiest_room
);

    import ras_pkg::*;

    localparam int IDX_W = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
    localparam int NUM_W = $clog2(MAX_ROOMS + 1);
    localparam int CMP_W = (NUM_W > CFG_W) ? NUM_W : CFG_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [NUM_W-1:0]      num_t;
    typedef logic [COUNT_BITS-1:0] cnt_t;

    localparam cnt_t CNT_MAX = '1;

    // storage
    tstamp_t busy_mem [MAX_ROOMS];
    cnt_t    cnt_mem  [MAX_ROOMS];
    logic [MAX_ROOMS-1:0] vld_reg, vld_next;

    // control
    logic [1:0] state_reg, state_next;
    cfg_t       cfg_reg;
    num_t       n_reg, n_next;
    num_t       iss_idx_reg, iss_idx_next;
    num_t       prc_idx_reg, prc_idx_next;
    logic       pend_reg;
    logic       rd_ok_reg;
    logic       found_reg, found_next;
    logic       last_reg, last_next;
    logic       out_valid_reg, out_valid_next;

    // job and scan payload
    start_t  start_reg, start_next;
    start_t  stop_reg, stop_next;
    start_t  dur_reg, dur_next;
    tstamp_t busy_rd_reg;
    cnt_t    cnt_rd_reg;
    idx_t    sel_idx_reg, sel_idx_next;
    cnt_t    sel_cnt_reg, sel_cnt_next;
    idx_t    early_idx_reg, early_idx_next;
    tstamp_t early_busy_reg, early_busy_next;
    cnt_t    early_cnt_reg, early_cnt_next;
    idx_t    best_idx_reg, best_idx_next;
    cnt_t    best_cnt_reg, best_cnt_next;

    room_t   room_reg, room_next;
    tstamp_t end_reg, end_next;
    logic    bvalid_reg, bvalid_next;
    room_t   broom_reg, broom_next;

    logic       issue;
    idx_t       rd_addr;
    tstamp_t    b_eff;
    cnt_t       c_eff;
    idx_t       prc_idx;
    logic       go;
    idx_t       chosen;
    cnt_t       cnt_raw, cnt_new;
    logic [TSTAMP_W:0] delay_sum;
    tstamp_t    finish;
    idx_t       best_fin;
    logic       wr_en;
    logic [CMP_W-1:0] cfg_ext;

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign room          = room_reg;
    assign actual_end    = end_reg;
    assign busiest_valid = bvalid_reg;
    assign busiest_room  = broom_reg;

    assign issue   = (state_reg == ST_SCAN) && (iss_idx_reg < n_reg);
    assign rd_addr = issue ? iss_idx_reg[IDX_W-1:0] : '0;
    assign b_eff   = rd_ok_reg ? busy_rd_reg : '0;
    assign c_eff   = rd_ok_reg ? cnt_rd_reg : '0;
    assign prc_idx = prc_idx_reg[IDX_W-1:0];
    assign go      = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    assign cfg_ext = CMP_W'(cfg_reg);

    always_comb
    begin
        chosen    = found_reg ? sel_idx_reg : early_idx_reg;
        cnt_raw   = found_reg ? sel_cnt_reg : early_cnt_reg;
        cnt_new   = (cnt_raw == CNT_MAX) ? cnt_raw : cnt_raw + 1'b1;
        delay_sum = {1'b0, early_busy_reg} + (TSTAMP_W + 1)'(dur_reg);
        if (found_reg)
        begin
            finish = TSTAMP_W'(stop_reg);
        end
        else if (delay_sum[TSTAMP_W])
        begin
            finish = TSTAMP_MAX;
        end
        else
        begin
            finish = delay_sum[TSTAMP_W-1:0];
        end
        // the chosen room only gained a use, so compare it against the old leader
        if (chosen == best_idx_reg)
        begin
            best_fin = best_idx_reg;
        end
        else if (cnt_new > best_cnt_reg)
        begin
            best_fin = chosen;
        end
        else if (cnt_new == best_cnt_reg && chosen < best_idx_reg)
        begin
            best_fin = chosen;
        end
        else
        begin
            best_fin = best_idx_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        n_next          = n_reg;
        iss_idx_next    = iss_idx_reg;
        prc_idx_next    = prc_idx_reg;
        found_next      = found_reg;
        last_next       = last_reg;
        start_next      = start_reg;
        stop_next       = stop_reg;
        dur_next        = dur_reg;
        sel_idx_next    = sel_idx_reg;
        sel_cnt_next    = sel_cnt_reg;
        early_idx_next  = early_idx_reg;
        early_busy_next = early_busy_reg;
        early_cnt_next  = early_cnt_reg;
        best_idx_next   = best_idx_reg;
        best_cnt_next   = best_cnt_reg;
        vld_next        = vld_reg;
        wr_en           = 1'b0;
        out_valid_next  = out_valid_reg && out_stall;
        room_next       = room_reg;
        end_next        = end_reg;
        bvalid_next     = bvalid_reg;
        broom_next      = broom_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (cfg_ext == '0)
                    begin
                        n_next = num_t'(1);
                    end
                    else if (cfg_ext > CMP_W'(MAX_ROOMS))
                    begin
                        n_next = num_t'(MAX_ROOMS);
                    end
                    else
                    begin
                        n_next = num_t'(cfg_ext);
                    end
                    start_next   = job_start;
                    stop_next    = (job_end < job_start) ? job_start : job_end;
                    dur_next     = (job_end < job_start) ? '0 : job_end - job_start;
                    last_next    = is_last;
                    found_next   = 1'b0;
                    iss_idx_next = '0;
                    prc_idx_next = '0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    iss_idx_next = iss_idx_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    prc_idx_next = prc_idx_reg + 1'b1;
                    if (!found_reg && b_eff <= TSTAMP_W'(start_reg))
                    begin
                        found_next   = 1'b1;
                        sel_idx_next = prc_idx;
                        sel_cnt_next = c_eff;
                    end
                    if (prc_idx_reg == '0 || b_eff < early_busy_reg)
                    begin
                        early_idx_next  = prc_idx;
                        early_busy_next = b_eff;
                        early_cnt_next  = c_eff;
                    end
                    if (prc_idx_reg == '0 || c_eff > best_cnt_reg)
                    begin
                        best_idx_next = prc_idx;
                        best_cnt_next = c_eff;
                    end
                    if (prc_idx_reg == n_reg - 1'b1)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (go)
                begin
                    out_valid_next = 1'b1;
                    room_next      = room_t'(chosen);
                    end_next       = finish;
                    bvalid_next    = last_reg;
                    broom_next     = last_reg ? room_t'(best_fin) : '0;
                    if (last_reg)
                    begin
                        vld_next = '0;
                    end
                    else
                    begin
                        wr_en            = 1'b1;
                        vld_next[chosen] = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // synchronous memories, one read and one write port each
    always_ff @(posedge clk)
    begin
        busy_rd_reg <= busy_mem[rd_addr];
        cnt_rd_reg  <= cnt_mem[rd_addr];
        if (wr_en)
        begin
            busy_mem[chosen] <= finish;
            cnt_mem[chosen]  <= cnt_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cfg_reg       <= cfg_t'(CFG_RESET);
            vld_reg       <= '0;
            pend_reg      <= 1'b0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            n_reg         <= num_t'(1);
            iss_idx_reg   <= '0;
            prc_idx_reg   <= '0;
            found_reg     <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (room_count_wr_en)
            begin
                cfg_reg <= room_count_wr_data;
            end
            vld_reg       <= vld_next;
            pend_reg      <= issue;
            rd_ok_reg     <= vld_reg[rd_addr];
            out_valid_reg <= out_valid_next;
            n_reg         <= n_next;
            iss_idx_reg   <= iss_idx_next;
            prc_idx_reg   <= prc_idx_next;
            found_reg     <= found_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg      <= start_next;
        stop_reg       <= stop_next;
        dur_reg        <= dur_next;
        sel_idx_reg    <= sel_idx_next;
        sel_cnt_reg    <= sel_cnt_next;
        early_idx_reg  <= early_idx_next;
        early_busy_reg <= early_busy_next;
        early_cnt_reg  <= early_cnt_next;
        best_idx_reg   <= best_idx_next;
        best_cnt_reg   <= best_cnt_next;
        room_reg       <= room_next;
        end_reg        <= end_next;
        bvalid_reg     <= bvalid_next;
        broom_reg      <= broom_next;
    end

`ifndef NO_ASSERTIONS
    a_done_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> out_valid_reg)
        else $error("finished job produced no result beat");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (prc_idx_reg < n_reg) && (iss_idx_reg <= n_reg))
        else $error("room scan ran past the rooms in use");

    a_set_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (go && last_reg) |=> (vld_reg == '0))
        else $error("room state not cleared after last job");

    a_busiest_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !bvalid_reg) |-> (broom_reg == '0))
        else $error("busiest room reported off the last job");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |=> (state_reg != ST_IDLE))
        else $error("scan skipped the result stage");
`endif

endmodule

`default_nettype wire

@@ tb/sv/room_allocation_scheduler_unit_tb.sv @@
// testbench for room_allocation_scheduler_unit: a directed table of jobs, then random job sets
// results are checked against the table's expected values or a built-in room placement predictor; depends on ras_pkg
module room_allocation_scheduler_unit_tb;
    import ras_pkg::*;

    localparam int ROOMS_BUILT = 16;
    localparam int USE_BITS = 20;
    localparam int RANDOM_JOBS = 1500;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES = 600;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        room_t   room;
        tstamp_t actual_end;
        logic    busiest_valid;
        room_t   busiest_room;
    } job_result_t;

    typedef struct {
        bit          typed;
        job_result_t want;
    } job_tag_t;

    typedef enum logic {ROW_JOB, ROW_ROOMS} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        cfg_t        rooms;
        start_t      start;
        start_t      stop;
        logic        last;
        bit          typed;
        job_result_t want;
    } dir_row_t;

    logic    clk;
    logic    rst_n;
    logic    room_count_wr_en;
    cfg_t    room_count_wr_data;
    logic    in_valid;
    logic    in_stall;
    start_t  job_start;
    start_t  job_end;
    logic    is_last;
    logic    out_valid;
    logic    out_stall;
    room_t   room;
    tstamp_t actual_end;
    logic    busiest_valid;
    room_t   busiest_room;

    tstamp_t               room_busy_until [ROOMS_BUILT];
    logic [USE_BITS-1:0]   room_uses [ROOMS_BUILT];
    cfg_t                  model_rooms;
    job_result_t           pending_results [$];
    job_tag_t              job_tags [$];
    dir_row_t              dir_rows [$];

    int jobs_sent;
    int results_seen;
    int errors;
    int sets_done;
    int delayed_jobs;
    int cycles;
    int idle_pct;
    int stall_pct;
    int hold_asked;
    int hold_taken;
    int hold_left;

    room_allocation_scheduler_unit #(
        .MAX_ROOMS  (ROOMS_BUILT),
        .COUNT_BITS (USE_BITS)
    ) u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .room_count_wr_en   (room_count_wr_en),
        .room_count_wr_data (room_count_wr_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .job_start          (job_start),
        .job_end            (job_end),
        .is_last            (is_last),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .room               (room),
        .actual_end         (actual_end),
        .busiest_valid      (busiest_valid),
        .busiest_room       (busiest_room)
    );

    always #1 clk = ~clk;

    function automatic void clear_rooms();
        for (int k = 0; k < ROOMS_BUILT; k++)
        begin
            room_busy_until[k] = '0;
            room_uses[k] = '0;
        end
    endfunction

    function automatic job_result_t place_job(input start_t s, input start_t e, input logic last);
        job_result_t res;
        tstamp_t     stop;
        tstamp_t     dur;
        tstamp_t     fin;
        int          n;
        int          pick;
        int          early;
        int          best;
        bit          hit;
        n = (model_rooms == 0) ? 1 :
            ((model_rooms > ROOMS_BUILT) ? ROOMS_BUILT : int'(model_rooms));
        stop = (e < s) ? tstamp_t'(s) : tstamp_t'(e);
        dur = stop - tstamp_t'(s);
        pick = 0;
        early = 0;
        hit = 1'b0;
        for (int k = 0; k < n && !hit; k++)
        begin
            if (room_busy_until[k] <= tstamp_t'(s))
            begin
                pick = k;
                hit = 1'b1;
            end
            else if (room_busy_until[k] < room_busy_until[early])
                early = k;
        end
        if (hit)
            fin = stop;
        else
        begin
            pick = early;
            fin = room_busy_until[early];
            fin = (TSTAMP_MAX - fin < dur) ? TSTAMP_MAX : fin + dur;
            delayed_jobs++;
        end
        room_busy_until[pick] = fin;
        if (room_uses[pick] != '1)
            room_uses[pick] = room_uses[pick] + 1'b1;
        res.room = room_t'(pick);
        res.actual_end = fin;
        res.busiest_valid = 1'b0;
        res.busiest_room = '0;
        if (last)
        begin
            best = 0;
            for (int k = 1; k < n; k++)
            begin
                if (room_uses[k] > room_uses[best])
                    best = k;
            end
            res.busiest_valid = 1'b1;
            res.busiest_room = room_t'(best);
            sets_done++;
            clear_rooms();
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : watch_beats
        job_result_t got;
        job_result_t want;
        job_tag_t    tag;
        if (!rst_n)
        begin
            model_rooms = cfg_t'(CFG_RESET);
            clear_rooms();
        end
        else
        begin
            if (room_count_wr_en)
                model_rooms = room_count_wr_data;
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual room %0d end %0h",
                             $time, room, actual_end);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("room", want.room, room);
                    check_field("actual_end", want.actual_end, actual_end);
                    check_field("busiest_valid", want.busiest_valid, busiest_valid);
                    check_field("busiest_room", want.busiest_room, busiest_room);
                end
            end
            if (in_valid && !in_stall)
            begin
                tag = job_tags.pop_front();
                got = place_job(job_start, job_end, is_last);
                pending_results.push_back(tag.typed ? tag.want : got);
            end
        end
    end

    // receiver: random stall, plus a long hold when asked
    always @(posedge clk)
    begin
        if (hold_taken != hold_asked)
        begin
            hold_taken = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic add_row(input row_kind_t kind, input cfg_t rooms, input start_t s,
                           input start_t e, input logic last, input bit typed, input room_t r,
                           input tstamp_t aend, input logic bv, input room_t br);
        dir_row_t row;
        row.kind = kind;
        row.rooms = rooms;
        row.start = s;
        row.stop = e;
        row.last = last;
        row.typed = typed;
        row.want.room = r;
        row.want.actual_end = aend;
        row.want.busiest_valid = bv;
        row.want.busiest_room = br;
        dir_rows.push_back(row);
    endtask

    task automatic send_job(input start_t s, input start_t e, input logic last, input bit typed,
                            input job_result_t want);
        int       gap;
        job_tag_t tag;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tag.typed = typed;
        tag.want = want;
        job_tags.push_back(tag);
        in_valid <= 1'b1;
        job_start <= s;
        job_end <= e;
        is_last <= last;
        do
            @(posedge clk);
        while (in_stall);
        jobs_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (results_seen < jobs_sent)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_rooms(input cfg_t v);
        drain_results();
        room_count_wr_en <= 1'b1;
        room_count_wr_data <= v;
        @(posedge clk);
        room_count_wr_en <= 1'b0;
    endtask

    initial
    begin
        int     phase;
        int     done_in_phase;
        int     set_len;
        int     pick;
        int     roll;
        start_t t_now;
        start_t s;
        start_t e;

        clk = 1'b0;
        rst_n = 1'b0;
        room_count_wr_en = 1'b0;
        room_count_wr_data = '0;
        in_valid = 1'b0;
        job_start = '0;
        job_end = '0;
        is_last = 1'b0;
        out_stall = 1'b0;
        jobs_sent = 0;
        results_seen = 0;
        errors = 0;
        sets_done = 0;
        delayed_jobs = 0;
        cycles = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_asked = 0;
        hold_taken = 0;
        hold_left = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sixteen rooms after reset, end before start, a reused room as busiest
        add_row(ROW_JOB, 0, 0, 10, 0, 1, 0, 48'd10, 0, 0);
        add_row(ROW_JOB, 0, 0, 32'hFFFF_FFFF, 0, 1, 1, 48'hFFFF_FFFF, 0, 0);
        add_row(ROW_JOB, 0, 5, 3, 0, 1, 2, 48'd5, 0, 0);
        add_row(ROW_JOB, 0, 5, 5, 1, 1, 2, 48'd5, 1, 2);
        // one room: every job after the first is delayed
        add_row(ROW_ROOMS, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_JOB, 0, 100, 200, 0, 1, 0, 48'd200, 0, 0);
        add_row(ROW_JOB, 0, 150, 160, 0, 1, 0, 48'd210, 0, 0);
        add_row(ROW_JOB, 0, 150, 150, 1, 1, 0, 48'd210, 1, 0);
        // zero rooms act as one, delay past 32 bits
        add_row(ROW_ROOMS, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_JOB, 0, 0, 32'hFFFF_FFFF, 0, 1, 0, 48'hFFFF_FFFF, 0, 0);
        add_row(ROW_JOB, 0, 0, 32'hFFFF_FFFF, 1, 1, 0, 48'h1_FFFF_FFFE, 1, 0);
        // out of order starts, room count changed inside a set
        add_row(ROW_ROOMS, 2, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_JOB, 0, 1000, 2000, 0, 1, 0, 48'd2000, 0, 0);
        add_row(ROW_JOB, 0, 500, 600, 0, 1, 1, 48'd600, 0, 0);
        add_row(ROW_JOB, 0, 100, 300, 0, 1, 1, 48'd800, 0, 0);
        add_row(ROW_ROOMS, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_JOB, 0, 0, 50, 0, 1, 0, 48'd2050, 0, 0);
        add_row(ROW_ROOMS, 3, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_JOB, 0, 0, 10, 1, 1, 2, 48'd10, 1, 0);
        // room count above the built count, field extremes
        add_row(ROW_ROOMS, 31, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_JOB, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_JOB, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
        add_row(ROW_JOB, 0, 0, 1, 0, 0, 0, 0, 0, 0);
        add_row(ROW_JOB, 0, 0, 32'hFFFF_FFFF, 1, 0, 0, 0, 0, 0);
        add_row(ROW_ROOMS, 16, 0, 0, 0, 0, 0, 0, 0, 0);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_ROOMS)
                write_rooms(dir_rows[i].rooms);
            else
                send_job(dir_rows[i].start, dir_rows[i].stop, dir_rows[i].last,
                         dir_rows[i].typed, dir_rows[i].want);
        end
        drain_results();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct = 0;
                    stall_pct <= 0;
                    hold_asked <= hold_asked + 1;
                end
                1:
                begin
                    idle_pct = 50;
                    stall_pct <= 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct <= 50;
                end
                default:
                begin
                    idle_pct = 13;
                    stall_pct <= 13;
                end
            endcase
            done_in_phase = 0;
            while (done_in_phase < RANDOM_JOBS / 4)
            begin
                if ($urandom_range(2) == 0)
                begin
                    pick = $urandom_range(9);
                    write_rooms((pick < 6) ? cfg_t'(pick + 1) : cfg_t'($urandom_range(31)));
                end
                set_len = $urandom_range(1, 24);
                t_now = ($urandom_range(3) == 0) ? start_t'($urandom)
                                                 : start_t'($urandom_range(1000));
                for (int j = 0; j < set_len; j++)
                begin
                    roll = $urandom_range(99);
                    if (roll < 8)
                    begin
                        s = $urandom;
                        e = $urandom;
                    end
                    else
                    begin
                        if (roll < 13)
                            s = t_now - $urandom_range(1, 60);
                        else
                        begin
                            t_now = t_now + $urandom_range(6);
                            s = t_now;
                        end
                        roll = $urandom_range(99);
                        if (roll < 6)
                            e = s - $urandom_range(2);
                        else if (roll < 12)
                            e = s + $urandom;
                        else
                            e = s + $urandom_range(1, 40);
                    end
                    send_job(s, e, j == set_len - 1, 1'b0, '0);
                end
                done_in_phase += set_len;
            end
            drain_results();
        end

        if (pending_results.size() != 0)
        begin
            errors += pending_results.size();
            $display("%0t: %0d results expected, actual none", $time, pending_results.size());
        end
        $display("tb: %0d jobs in %0d sets, %0d placed late for lack of a free room",
                 jobs_sent, sets_done, delayed_jobs);
        $display("tb: %0d results checked, %0d mismatches", results_seen, errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
